// ===== hw/rtl/rcw_pkg.sv =====
// ----------------------------------------------------------------------------
// rcw_pkg
// Types and constants shared by the wall column raycaster modules.
// ----------------------------------------------------------------------------
package rcw_pkg;

    localparam int MAP_SIZE      = 32;
    localparam int MAP_BITS      = 5;
    localparam int TEX_SIZE      = 64;
    localparam int TEX_BITS      = 6;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 64;
    localparam int ONE_Q16       = 65536;
    // cam = column * 2 * ONE / SCREEN_WIDTH - ONE, as a shift
    localparam int CAM_SHIFT     = 11;

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] MODE_CAST   = 2'd0;
    localparam logic [1:0] MODE_MAP_WR = 2'd1;
    localparam logic [1:0] MODE_TEX_WR = 2'd2;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;

    typedef enum logic [1:0] {
        OP_CAST,
        OP_MAP_WR,
        OP_TEX_WR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [5:0]  column;
        logic [9:0]  map_addr;
        logic [3:0]  cell_value;
        logic [13:0] tex_addr;
        logic [23:0] texel_color;
    } t_item;

    typedef struct packed {
        logic        last;
        logic [23:0] color;
        logic [5:0]  column;
        logic [5:0]  row;
    } t_pixel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RAY,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_SIDE,
        S_STEP,
        S_CHK,
        S_LOOK,
        S_PERP,
        S_DH_GO,
        S_DH_WAIT,
        S_HIT,
        S_DT_GO,
        S_DT_WAIT,
        S_TPOS,
        S_PIX,
        S_PLOAD
    } t_state;

endpackage

// ===== hw/rtl/textured_wall_column_raycaster_top.sv =====
// ----------------------------------------------------------------------------
// textured_wall_column_raycaster_top
// Casts one screen column per item over a 32x32 map and streams its
// textured wall pixels; also takes map cell and texel writes.
// ----------------------------------------------------------------------------
// Map writes and texel writes are done by the back end in its idle state. A
// cast uses up to four divisions (two ray deltas, wall height, texture step)
// that share one radix-2 divider, reads the map memory once per grid step
// walked and reads the texture memory once per pixel drawn. A two-item queue
// lets new items in while a cast runs; the map and texture memories are
// undefined until written.
module textured_wall_column_raycaster_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column, cell_x, cell_y, cell_value, texture_index, texel_row,
    // texel_col, texel_color, zero fill
    input  logic [63:0] s_axis_tdata,
    // mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_row, pixel_column, pixel_color, zero fill
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import rcw_pkg::*;

    logic   w_q_valid;
    logic   w_q_ready;
    t_item  w_q_item;
    t_pixel w_pix;

    rcw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (w_q_valid),
        .i_q_ready     (w_q_ready),
        .o_q_item      (w_q_item)
    );

    rcw_cast u_cast (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_item    (w_q_item),
        .o_pix_valid (m_axis_tvalid),
        .i_pix_ready (m_axis_tready),
        .o_pix       (w_pix)
    );

    assign m_axis_tdata = {4'd0, w_pix.color, w_pix.column, w_pix.row};
    assign m_axis_tlast = w_pix.last;

endmodule

// ===== hw/rtl/rcw_ram.sv =====
// ----------------------------------------------------------------------------
// rcw_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rcw_div.sv =====
// ----------------------------------------------------------------------------
// rcw_div
// Restoring unsigned divider, 33-bit numerator by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcw_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quo
);

    localparam logic [5:0] LAST_STEP = 6'd32;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [32:0] r_q;
    logic [31:0] r_den;
    logic [32:0] w_rem_sh;
    logic        w_fit;

    assign w_rem_sh = {r_rem, r_q[32]};
    assign w_fit    = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? 32'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[31:0];
            r_q   <= {r_q[31:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== hw/rtl/rcw_front.sv =====
// ----------------------------------------------------------------------------
// rcw_front
// Accepts input items, classifies them by mode and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rcw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [63:0]    s_axis_tdata,
    input  logic [1:0]     s_axis_tuser,
    output logic           o_q_valid,
    input  logic           i_q_ready,
    output rcw_pkg::t_item o_q_item
);
    import rcw_pkg::*;

    t_item      r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_keep;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item.column      = s_axis_tdata[5:0];
        w_item.map_addr    = {s_axis_tdata[15:11], s_axis_tdata[10:6]};
        w_item.cell_value  = s_axis_tdata[19:16];
        w_item.tex_addr    = {s_axis_tdata[21:20], s_axis_tdata[27:22],
                              s_axis_tdata[33:28]};
        w_item.texel_color = s_axis_tdata[57:34];
        w_item.op          = OP_CAST;
        w_keep             = 1'b1;
        case (s_axis_tuser)
            MODE_CAST:   w_item.op = OP_CAST;
            MODE_MAP_WR: w_item.op = OP_MAP_WR;
            MODE_TEX_WR: w_item.op = OP_TEX_WR;
            default:     w_keep    = 1'b0;
        endcase
    end

    assign s_axis_tready = r_cnt != 2'd2;
    assign o_q_valid     = r_cnt != 2'd0;
    assign o_q_item      = r_buf[r_rp];
    // drop unknown modes at the door
    assign w_push        = s_axis_tvalid && s_axis_tready && w_keep;
    assign w_pop         = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_item;
        end
    end

endmodule

// ===== hw/rtl/rcw_cast.sv =====
// ----------------------------------------------------------------------------
// rcw_cast
// Back end: executes map and texel writes, casts one column by DDA grid
// walk and emits its textured pixels.
// ----------------------------------------------------------------------------
module rcw_cast (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [20:0]     i_cfg_data,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  rcw_pkg::t_item  i_q_item,
    output logic            o_pix_valid,
    input  logic            i_pix_ready,
    output rcw_pkg::t_pixel o_pix
);
    import rcw_pkg::*;

    localparam logic [6:0] HALF_H = 7'(SCREEN_HEIGHT / 2);
    localparam logic [6:0] FULL_H = 7'(SCREEN_HEIGHT);

    t_state r_state, n_state;

    logic [20:0]        r_pos_x, r_pos_y;
    logic signed [17:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    logic [5:0]         r_col;
    logic signed [18:0] r_rx, r_ry;
    logic [30:0]        r_ddx, r_ddy;
    logic [38:0]        r_sdx, r_sdy;
    logic signed [6:0]  r_mx, r_my;
    logic               r_side;
    logic [30:0]        r_perp;
    logic [22:0]        r_height;
    logic [22:0]        r_tstep;
    logic [21:0]        r_tpos;
    logic [TEX_BITS-1:0] r_tx;
    logic [1:0]         r_face;
    logic [6:0]         r_row, r_lower;
    t_pixel             r_pix;
    logic               r_pix_valid;

    // ray setup
    logic signed [18:0] w_cam;
    logic signed [36:0] w_pmx, w_pmy;
    logic [18:0]        w_arx, w_ary;
    logic [16:0]        w_frx, w_fry;
    logic [47:0]        w_sdx0, w_sdy0;
    logic [38:0]        w_pd;
    logic signed [50:0] w_hp;
    logic [15:0]        w_hit;
    logic [21:0]        w_hh;
    logic [44:0]        w_tp0;
    logic [30:0]        w_dsat;
    logic               w_oob;
    logic               w_wall;
    logic               w_out_free;
    logic               w_last;

    // divider
    logic        w_div_start;
    logic [32:0] w_div_num;
    logic [31:0] w_div_den;
    logic        w_div_done;
    logic [32:0] w_div_quo;

    // memories
    logic        w_map_we, w_map_re;
    logic [9:0]  w_map_raddr;
    logic [3:0]  w_map_rdata;
    logic        w_tex_we, w_tex_re;
    logic [13:0] w_tex_raddr;
    logic [23:0] w_tex_rdata;

    assign w_cam = $signed(19'(r_col) << CAM_SHIFT) - 19'sd65536;
    assign w_pmx = 37'(r_plane_x) * 37'(w_cam);
    assign w_pmy = 37'(r_plane_y) * 37'(w_cam);
    assign w_arx = r_rx[18] ? 19'(-r_rx) : 19'(r_rx);
    assign w_ary = r_ry[18] ? 19'(-r_ry) : 19'(r_ry);

    assign w_frx  = r_rx[18] ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
    assign w_fry  = r_ry[18] ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};
    assign w_sdx0 = 48'(w_frx) * 48'(r_ddx);
    assign w_sdy0 = 48'(w_fry) * 48'(r_ddy);

    assign w_pd  = r_side ? r_sdy - 39'(r_ddy) : r_sdx - 39'(r_ddx);
    assign w_hp  = 51'($signed({1'b0, r_perp})) * 51'(r_side ? r_rx : r_ry);
    assign w_hit = (r_side ? r_pos_x[15:0] : r_pos_y[15:0]) + w_hp[31:16];
    assign w_hh  = r_height[22:1];
    assign w_tp0 = 45'(w_hh - 22'(HALF_H)) * 45'(r_tstep);

    assign w_dsat = (w_div_quo[32:31] != 2'b00) ? DIST_MAX : w_div_quo[30:0];

    // cells outside the map count as wall
    assign w_oob  = (r_mx < 0) || (r_mx >= 7'(MAP_SIZE)) ||
                    (r_my < 0) || (r_my >= 7'(MAP_SIZE));
    assign w_wall = w_oob || (w_map_rdata != 4'd0);

    assign w_out_free = !r_pix_valid || i_pix_ready;
    assign w_last     = r_row == r_lower - 7'd1;

    assign w_map_raddr = {r_my[MAP_BITS-1:0], r_mx[MAP_BITS-1:0]};
    assign w_tex_raddr = {r_face, r_tpos[16 +: TEX_BITS], r_tx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_ready   = 1'b0;
        w_map_we    = 1'b0;
        w_tex_we    = 1'b0;
        w_map_re    = 1'b0;
        w_tex_re    = 1'b0;
        w_div_start = 1'b0;
        w_div_num   = 33'h1_0000_0000;
        w_div_den   = {13'd0, w_arx};
        case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    case (i_q_item.op)
                        OP_MAP_WR: w_map_we = 1'b1;
                        OP_TEX_WR: w_tex_we = 1'b1;
                        OP_CAST:   n_state  = S_RAY;
                        default:   n_state  = S_IDLE;
                    endcase
                end
            end
            S_RAY: n_state = S_DX_GO;
            S_DX_GO: begin
                w_div_start = w_arx != 19'd0;
                n_state     = (w_arx != 19'd0) ? S_DX_WAIT : S_DY_GO;
            end
            S_DX_WAIT: if (w_div_done) n_state = S_DY_GO;
            S_DY_GO: begin
                w_div_den   = {13'd0, w_ary};
                w_div_start = w_ary != 19'd0;
                n_state     = (w_ary != 19'd0) ? S_DY_WAIT : S_SIDE;
            end
            S_DY_WAIT: if (w_div_done) n_state = S_SIDE;
            S_SIDE:  n_state = S_STEP;
            S_STEP:  n_state = S_CHK;
            S_CHK: begin
                w_map_re = 1'b1;
                n_state  = S_LOOK;
            end
            S_LOOK:  n_state = w_wall ? S_PERP : S_STEP;
            S_PERP:  n_state = S_DH_GO;
            S_DH_GO: begin
                w_div_num   = 33'(SCREEN_HEIGHT * ONE_Q16);
                w_div_den   = {1'b0, r_perp};
                w_div_start = 1'b1;
                n_state     = S_DH_WAIT;
            end
            S_DH_WAIT: begin
                // heights below two draw nothing
                if (w_div_done) begin
                    n_state = (w_div_quo[22:1] == 22'd0) ? S_IDLE : S_HIT;
                end
            end
            S_HIT: n_state = S_DT_GO;
            S_DT_GO: begin
                w_div_num   = 33'(TEX_SIZE * ONE_Q16);
                w_div_den   = {9'd0, r_height};
                w_div_start = 1'b1;
                n_state     = S_DT_WAIT;
            end
            S_DT_WAIT: if (w_div_done) n_state = S_TPOS;
            S_TPOS: n_state = S_PIX;
            S_PIX: begin
                if (w_out_free) begin
                    w_tex_re = 1'b1;
                    n_state  = S_PLOAD;
                end
            end
            S_PLOAD: n_state = w_last ? S_IDLE : S_PIX;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 21'd98304;
            r_pos_y   <= 21'd98304;
            r_dir_x   <= -18'sd65536;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= 18'sd43253;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data[17:0];
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data[17:0];
                CFG_PLANE_X: r_plane_x <= i_cfg_data[17:0];
                CFG_PLANE_Y: r_plane_y <= i_cfg_data[17:0];
                default:     r_pos_x   <= r_pos_x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (r_state == S_PLOAD) begin
            r_pix_valid <= 1'b1;
        end else if (i_pix_ready) begin
            r_pix_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_col <= i_q_item.column;
            S_RAY: begin
                r_rx <= $signed(19'(r_dir_x)) + $signed(w_pmx[34:16]);
                r_ry <= $signed(19'(r_dir_y)) + $signed(w_pmy[34:16]);
            end
            S_DX_GO:   if (w_arx == 19'd0) r_ddx <= DIST_MAX;
            S_DX_WAIT: if (w_div_done) r_ddx <= w_dsat;
            S_DY_GO:   if (w_ary == 19'd0) r_ddy <= DIST_MAX;
            S_DY_WAIT: if (w_div_done) r_ddy <= w_dsat;
            S_SIDE: begin
                r_sdx <= {7'd0, w_sdx0[47:16]};
                r_sdy <= {7'd0, w_sdy0[47:16]};
                r_mx  <= {2'b00, r_pos_x[20:16]};
                r_my  <= {2'b00, r_pos_y[20:16]};
            end
            S_STEP: begin
                // ties step along y
                if (r_sdx < r_sdy) begin
                    r_sdx  <= r_sdx + 39'(r_ddx);
                    r_mx   <= r_rx[18] ? r_mx - 7'sd1 : r_mx + 7'sd1;
                    r_side <= 1'b0;
                end else begin
                    r_sdy  <= r_sdy + 39'(r_ddy);
                    r_my   <= r_ry[18] ? r_my - 7'sd1 : r_my + 7'sd1;
                    r_side <= 1'b1;
                end
            end
            S_PERP: begin
                if (w_pd == 39'd0) begin
                    r_perp <= 31'd1;
                end else if (w_pd > 39'(DIST_MAX)) begin
                    r_perp <= DIST_MAX;
                end else begin
                    r_perp <= w_pd[30:0];
                end
            end
            S_DH_WAIT: if (w_div_done) r_height <= w_div_quo[22:0];
            S_HIT: begin
                r_tx <= w_hit[15 -: TEX_BITS];
                if (r_side) begin
                    r_face <= (!r_ry[18] && r_ry != 19'sd0) ? 2'd0 : 2'd1;
                end else begin
                    r_face <= (!r_rx[18] && r_rx != 19'sd0) ? 2'd2 : 2'd3;
                end
            end
            S_DT_WAIT: if (w_div_done) r_tstep <= w_div_quo[22:0];
            S_TPOS: begin
                // span at least as tall as the screen: start texture part way down
                if (w_hh >= 22'(HALF_H)) begin
                    r_row   <= '0;
                    r_lower <= FULL_H;
                    r_tpos  <= w_tp0[21:0];
                end else begin
                    r_row   <= HALF_H - w_hh[6:0];
                    r_lower <= HALF_H + w_hh[6:0];
                    r_tpos  <= '0;
                end
            end
            S_PLOAD: begin
                r_pix.row    <= r_row[5:0];
                r_pix.column <= r_col;
                r_pix.color  <= w_tex_rdata;
                r_pix.last   <= w_last;
                r_row        <= r_row + 7'd1;
                r_tpos       <= r_tpos + r_tstep[21:0];
            end
            default: r_row <= r_row;
        endcase
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;

    rcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    rcw_ram #(
        .WIDTH (4),
        .DEPTH (MAP_SIZE * MAP_SIZE)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (i_q_item.map_addr),
        .i_wdata (i_q_item.cell_value),
        .i_re    (w_map_re),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    rcw_ram #(
        .WIDTH (24),
        .DEPTH (4 * TEX_SIZE * TEX_SIZE)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (w_tex_we),
        .i_waddr (i_q_item.tex_addr),
        .i_wdata (i_q_item.texel_color),
        .i_re    (w_tex_re),
        .i_raddr (w_tex_raddr),
        .o_rdata (w_tex_rdata)
    );

endmodule
